// ----- sv/spci_pkg.sv -----
// ----------------------------------------------------------------------------
// spci_pkg
// Shared types and constants for the sparse pattern compressed index block.
// ----------------------------------------------------------------------------
package spci_pkg;

    localparam int MaxDim     = 64;
    localparam int MaxEntries = 4096;
    localparam int DimW       = $clog2(MaxDim);
    localparam int DimCntW    = $clog2(MaxDim + 1);
    localparam int EntW       = $clog2(MaxEntries);
    localparam int EntCntW    = $clog2(MaxEntries + 1);
    localparam int LineW      = 7;

    typedef enum logic [1:0] {
        OP_LOAD  = 2'd0,
        OP_BUILD = 2'd1,
        OP_QUERY = 2'd2,
        OP_BAD   = 2'd3
    } op_t;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_RANGE = 2'd1,
        ST_DUP   = 2'd2,
        ST_BADQ  = 2'd3
    } status_t;

    localparam logic CfgRows = 1'b0;
    localparam logic CfgCols = 1'b1;

    typedef enum logic [3:0] {
        S_IDLE,
        S_LOAD_RD,
        S_LOAD_CHK,
        S_BR_RD,
        S_BR_SCAN,
        S_BC_RD,
        S_BC_SCAN,
        S_B_DONE,
        S_Q_RD0,
        S_Q_RD1,
        S_Q_CNT,
        S_Q_EMIT,
        S_Q_DATA,
        S_OUT
    } state_t;

    typedef struct packed {
        logic [LineW-1:0] line_index;
        logic             last;
        logic             empty_res;
        logic [LineW-1:0] max_count;
        status_t          status;
    } result_t;

    function automatic logic [DimCntW-1:0] eff_dim(input logic [6:0] v);
        logic [DimCntW-1:0] r;
        begin
            if (v == 7'd0)
                r = DimCntW'(1);
            else if (32'(v) > MaxDim)
                r = DimCntW'(MaxDim);
            else
                r = DimCntW'(v);
            return r;
        end
    endfunction

endpackage

// ----- sv/spci_if.sv -----
// ----------------------------------------------------------------------------
// spci_if
// Valid/ready channels for input items and result items.
// ----------------------------------------------------------------------------
interface spci_in_if;
    import spci_pkg::*;
    logic       valid;
    logic       ready;
    logic [1:0] operation;
    logic [5:0] entry_row;
    logic [5:0] entry_col;
    logic [6:0] query_index;
    modport source (output valid, operation, entry_row, entry_col, query_index, input ready);
    modport sink (input valid, operation, entry_row, entry_col, query_index, output ready);
endinterface

interface spci_out_if;
    import spci_pkg::*;
    logic       valid;
    logic       ready;
    logic [6:0] line_index;
    logic       last;
    logic       empty_res;
    logic [6:0] max_count;
    logic [1:0] status;
    modport source (output valid, line_index, last, empty_res, max_count, status, input ready);
    modport sink (input valid, line_index, last, empty_res, max_count, status, output ready);
endinterface

// ----- sv/spci_ram.sv -----
// ----------------------------------------------------------------------------
// spci_ram
// Single write, single registered read port memory.
// ----------------------------------------------------------------------------
module spci_ram #(
    parameter int Depth = 4096,
    parameter int Width = 6
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(Depth)-1:0] waddr,
    input  logic [Width-1:0]         wdata,
    input  logic [$clog2(Depth)-1:0] raddr,
    output logic [Width-1:0]         rdata
);
    logic [Width-1:0] mem [Depth];

    always_ff @(posedge clk)
    begin
        if (we)
            mem[waddr] <= wdata;
        rdata <= mem[raddr];
    end
endmodule

// ----- sv/sparse_pattern_crs_ccs_index_core.sv -----
// ----------------------------------------------------------------------------
// sparse_pattern_crs_ccs_index_core
// Loads nonzero coordinates, builds compressed row/column index tables and
// answers line intersection queries.
// ----------------------------------------------------------------------------
//  channel  | dir | contents
//  in_ch    | in  | operation, entry_row, entry_col, query_index
//  out_ch   | out | line_index, last, empty_res, max_count, status
//  cfg      | in  | cfg_we, cfg_index, cfg_data (num_rows, num_cols)
//
// load: accept, map row read, check, output.
// build: accept, row pass, column pass (a row read per bit), done state,
// output; one map bit per step through the shared row read.
// query: accept, Q_RD0, Q_RD1 and Q_CNT for the two start words, then per
// result: entry read, capture, output. after reset a clearing pass zeroes
// all 64 map rows. output is held until taken; input is not ready meanwhile.
module sparse_pattern_crs_ccs_index_core
    import spci_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    spci_in_if.sink      in_ch,
    spci_out_if.source   out_ch,
    input  logic         cfg_we,
    input  logic         cfg_index,
    input  logic [6:0]   cfg_data
);
    state_t state_reg, state_next;

    logic [6:0] rows_reg, cols_reg;
    logic       built_reg;
    logic [EntCntW-1:0] count_reg;
    logic [DimCntW-1:0] m, n;
    assign m = eff_dim(rows_reg);
    assign n = eff_dim(cols_reg);

    // clearing pass
    logic           clr_busy_reg;
    logic [DimW-1:0] clr_ptr_reg;

    // captured input
    logic [1:0] op_reg;
    logic [5:0] er_reg, ec_reg;
    logic [6:0] q_reg;

    // occupancy map, one row per word
    logic [MaxDim-1:0] occ [MaxDim];
    logic [MaxDim-1:0] occ_rd_reg;
    logic [DimW-1:0]   occ_raddr;
    logic              occ_we;
    logic [DimW-1:0]   occ_waddr;
    logic [MaxDim-1:0] occ_wdata;

    always_ff @(posedge clk)
    begin
        if (occ_we)
            occ[occ_waddr] <= occ_wdata;
        occ_rd_reg <= occ[occ_raddr];
    end

    // start tables
    logic [EntCntW-1:0] rst_tab [MaxDim+1];
    logic [EntCntW-1:0] cst_tab [MaxDim+1];
    logic [EntCntW-1:0] tab_rd_reg;
    logic               tab_sel;
    logic [DimCntW-1:0] tab_raddr;
    logic               rtab_we, ctab_we;
    logic [DimCntW-1:0] tab_waddr;
    logic [EntCntW-1:0] tab_wdata;

    always_ff @(posedge clk)
    begin
        if (rtab_we)
            rst_tab[tab_waddr] <= tab_wdata;
        if (ctab_we)
            cst_tab[tab_waddr] <= tab_wdata;
        tab_rd_reg <= tab_sel ? cst_tab[tab_raddr] : rst_tab[tab_raddr];
    end

    // scan counters
    logic [DimCntW-1:0] outer_reg, outer_next;
    logic [DimCntW-1:0] inner_reg, inner_next;
    logic [EntCntW-1:0] pos_reg, pos_next, line_start_reg, line_start_next;
    logic [DimCntW-1:0] best_reg, best_next;
    logic [EntCntW-1:0] first_reg, first_next, cnt_reg, cnt_next;
    logic               is_row_reg, is_row_next;
    logic [DimCntW-1:0] emit_i_reg, emit_i_next;

    // entry memories
    logic           cor_we, roc_we;
    logic [EntW-1:0] ent_waddr, ent_raddr;
    logic [DimW-1:0] ent_wdata, cor_rd, roc_rd;

    spci_ram #(.Depth(MaxEntries), .Width(DimW)) u_cor (
        .clk(clk), .we(cor_we), .waddr(ent_waddr), .wdata(ent_wdata),
        .raddr(ent_raddr), .rdata(cor_rd));
    spci_ram #(.Depth(MaxEntries), .Width(DimW)) u_roc (
        .clk(clk), .we(roc_we), .waddr(ent_waddr), .wdata(ent_wdata),
        .raddr(ent_raddr), .rdata(roc_rd));

    result_t res_reg, res_next;
    logic    out_valid_reg, out_valid_next;

    assign in_ch.ready = (state_reg == S_IDLE) && !clr_busy_reg;
    logic in_fire;
    assign in_fire = in_ch.valid && in_ch.ready;
    logic out_fire;
    assign out_fire = out_valid_reg && out_ch.ready;

    assign out_ch.valid      = out_valid_reg;
    assign out_ch.line_index = res_reg.line_index;
    assign out_ch.last       = res_reg.last;
    assign out_ch.empty_res  = res_reg.empty_res;
    assign out_ch.max_count  = res_reg.max_count;
    assign out_ch.status     = res_reg.status;

    // scan bit: map row is outer in row pass, inner in column pass
    logic [DimW-1:0] scan_bit_idx;
    logic            scan_bit;
    assign scan_bit_idx = (state_reg == S_BR_SCAN) ? inner_reg[DimW-1:0] : outer_reg[DimW-1:0];
    assign scan_bit     = occ_rd_reg[scan_bit_idx];

    logic [EntCntW-1:0] line_cnt;
    assign line_cnt = pos_reg - line_start_reg;

    logic [7:0] m_plus_n;
    assign m_plus_n = 8'(m) + 8'(n);

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_fire)
                begin
                    unique case (op_t'(in_ch.operation))
                        OP_LOAD:  state_next = S_LOAD_RD;
                        OP_BUILD: state_next = S_BR_RD;
                        OP_QUERY:
                            if (built_reg && {1'b0, in_ch.query_index} < m_plus_n)
                                state_next = S_Q_RD0;
                            else
                                state_next = S_OUT;
                        OP_BAD:   state_next = S_OUT;
                    endcase
                end
            end
            S_LOAD_RD:  state_next = S_LOAD_CHK;
            S_LOAD_CHK: state_next = S_OUT;
            S_BR_RD:    state_next = S_BR_SCAN;
            S_BR_SCAN:
                if (inner_reg == n)
                    state_next = (outer_reg + 1'b1 == m) ? S_BC_RD : S_BR_RD;
            S_BC_RD:    state_next = S_BC_SCAN;
            S_BC_SCAN:
                if (inner_reg == m)
                    state_next = (outer_reg + 1'b1 == n) ? S_B_DONE : S_BC_RD;
                else
                    state_next = S_BC_RD;
            S_B_DONE:   state_next = S_OUT;
            S_Q_RD0:    state_next = S_Q_RD1;
            S_Q_RD1:    state_next = S_Q_CNT;
            S_Q_CNT:    state_next = (cnt_next == '0) ? S_OUT : S_Q_EMIT;
            S_Q_EMIT:   state_next = S_Q_DATA;
            S_Q_DATA:   state_next = S_OUT;
            S_OUT:
                if (out_fire)
                    state_next = (op_reg == OP_QUERY && !res_reg.last) ? S_Q_EMIT : S_IDLE;
            default:    state_next = S_IDLE;
        endcase
    end

    // datapath and outputs
    always_comb
    begin
        outer_next      = outer_reg;
        inner_next      = inner_reg;
        pos_next        = pos_reg;
        line_start_next = line_start_reg;
        best_next       = best_reg;
        first_next      = first_reg;
        cnt_next        = cnt_reg;
        is_row_next     = is_row_reg;
        emit_i_next     = emit_i_reg;
        res_next        = res_reg;
        out_valid_next  = out_valid_reg;
        occ_raddr       = '0;
        occ_we          = 1'b0;
        occ_waddr       = clr_ptr_reg;
        occ_wdata       = '0;
        tab_sel         = 1'b0;
        tab_raddr       = '0;
        rtab_we         = 1'b0;
        ctab_we         = 1'b0;
        tab_waddr       = '0;
        tab_wdata       = '0;
        cor_we          = 1'b0;
        roc_we          = 1'b0;
        ent_waddr       = pos_reg[EntW-1:0];
        ent_wdata       = '0;
        ent_raddr       = '0;
        if (clr_busy_reg)
            occ_we = 1'b1;
        unique case (state_reg)
            S_IDLE:
            begin
                occ_raddr = in_ch.entry_row;
                outer_next = '0;
                inner_next = '0;
                pos_next = '0;
                line_start_next = '0;
                best_next = '0;
                emit_i_next = '0;
                res_next = '{line_index: '0, last: 1'b1, empty_res: 1'b0,
                             max_count: '0, status: ST_BADQ};
                if (in_fire && op_t'(in_ch.operation) == OP_BUILD)
                begin
                    rtab_we = 1'b1;
                    ctab_we = 1'b1;
                    tab_waddr = '0;
                    tab_wdata = '0;
                end
                if (in_fire && (op_t'(in_ch.operation) == OP_BAD ||
                    (op_t'(in_ch.operation) == OP_QUERY &&
                     !(built_reg && {1'b0, in_ch.query_index} < m_plus_n))))
                    out_valid_next = 1'b1;
            end
            S_LOAD_RD:
                occ_raddr = er_reg;
            S_LOAD_CHK:
            begin
                out_valid_next = 1'b1;
                if ({1'b0, er_reg} >= m || {1'b0, ec_reg} >= n)
                    res_next.status = ST_RANGE;
                else if (occ_rd_reg[ec_reg])
                    res_next.status = ST_DUP;
                else if (32'(count_reg) >= MaxEntries)
                    res_next.status = ST_RANGE;
                else
                begin
                    res_next.status = ST_OK;
                    occ_we = 1'b1;
                    occ_waddr = er_reg;
                    occ_wdata = occ_rd_reg | (MaxDim'(1) << ec_reg);
                end
            end
            S_BR_RD:
            begin
                occ_raddr = outer_reg[DimW-1:0];
                inner_next = '0;
            end
            S_BR_SCAN:
            begin
                occ_raddr = outer_reg[DimW-1:0];
                if (inner_reg == n)
                begin
                    if (DimCntW'(line_cnt) > best_reg)
                        best_next = DimCntW'(line_cnt);
                    rtab_we = 1'b1;
                    tab_waddr = outer_reg + 1'b1;
                    tab_wdata = pos_reg;
                    line_start_next = pos_reg;
                    outer_next = outer_reg + 1'b1;
                    if (outer_reg + 1'b1 == m)
                    begin
                        outer_next = '0;
                        pos_next = '0;
                        line_start_next = '0;
                    end
                    inner_next = '0;
                end
                else
                begin
                    if (scan_bit && 32'(pos_reg) < MaxEntries)
                    begin
                        cor_we = 1'b1;
                        ent_wdata = inner_reg[DimW-1:0];
                        pos_next = pos_reg + 1'b1;
                    end
                    inner_next = inner_reg + 1'b1;
                end
            end
            S_BC_RD:
                occ_raddr = inner_reg[DimW-1:0];
            S_BC_SCAN:
            begin
                if (inner_reg == m)
                begin
                    if (DimCntW'(line_cnt) > best_reg)
                        best_next = DimCntW'(line_cnt);
                    ctab_we = 1'b1;
                    tab_waddr = outer_reg + 1'b1;
                    tab_wdata = pos_reg;
                    line_start_next = pos_reg;
                    outer_next = outer_reg + 1'b1;
                    inner_next = '0;
                end
                else
                begin
                    if (scan_bit && 32'(pos_reg) < MaxEntries)
                    begin
                        roc_we = 1'b1;
                        ent_wdata = inner_reg[DimW-1:0];
                        pos_next = pos_reg + 1'b1;
                    end
                    inner_next = inner_reg + 1'b1;
                end
            end
            S_B_DONE:
            begin
                out_valid_next = 1'b1;
                res_next.status = ST_OK;
                res_next.max_count = LineW'(best_reg);
            end
            S_Q_RD0:
            begin
                tab_sel = !is_row_reg;
                tab_raddr = is_row_reg ? DimCntW'(q_reg) : DimCntW'(q_reg - 7'(m));
                outer_next = tab_raddr + 1'b1;
            end
            S_Q_RD1:
            begin
                // start word of the line arrives here, end word next cycle
                tab_sel = !is_row_reg;
                tab_raddr = outer_reg;
                first_next = tab_rd_reg;
            end
            S_Q_CNT:
            begin
                cnt_next = tab_rd_reg - first_reg;
                if (32'(cnt_next) > MaxDim)
                    cnt_next = EntCntW'(MaxDim);
                if (cnt_next == '0)
                begin
                    out_valid_next = 1'b1;
                    res_next = '{line_index: '0, last: 1'b1, empty_res: 1'b1,
                                 max_count: '0, status: ST_OK};
                end
            end
            S_Q_EMIT:
                ent_raddr = EntW'(first_reg + EntCntW'(emit_i_reg));
            S_Q_DATA:
            begin
                out_valid_next = 1'b1;
                res_next.line_index = is_row_reg ? LineW'(cor_rd) + LineW'(m)
                                                 : LineW'(roc_rd);
                res_next.last       = (EntCntW'(emit_i_reg) + 1'b1 == cnt_reg);
                res_next.empty_res  = 1'b0;
                res_next.max_count  = '0;
                res_next.status     = ST_OK;
                emit_i_next         = emit_i_reg + 1'b1;
            end
            S_OUT:
            begin
                if (out_fire)
                    out_valid_next = 1'b0;
            end
            default: ;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            rows_reg      <= 7'd64;
            cols_reg      <= 7'd64;
            built_reg     <= 1'b0;
            count_reg     <= '0;
            clr_busy_reg  <= 1'b1;
            clr_ptr_reg   <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (clr_busy_reg)
            begin
                clr_ptr_reg <= clr_ptr_reg + 1'b1;
                if (clr_ptr_reg == DimW'(MaxDim - 1))
                    clr_busy_reg <= 1'b0;
            end
            if (cfg_we)
            begin
                if (cfg_index == CfgRows)
                    rows_reg <= cfg_data;
                else
                    cols_reg <= cfg_data;
                built_reg <= 1'b0;
            end
            if (state_reg == S_LOAD_CHK && res_next.status == ST_OK)
            begin
                count_reg <= count_reg + 1'b1;
                built_reg <= 1'b0;
            end
            if (state_reg == S_B_DONE)
                built_reg <= 1'b1;
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            op_reg     <= in_ch.operation;
            er_reg     <= in_ch.entry_row;
            ec_reg     <= in_ch.entry_col;
            q_reg      <= in_ch.query_index;
            is_row_reg <= {1'b0, in_ch.query_index} < 8'(m);
        end
        else
            is_row_reg <= is_row_next;
        outer_reg      <= outer_next;
        inner_reg      <= inner_next;
        pos_reg        <= pos_next;
        line_start_reg <= line_start_next;
        best_reg       <= best_next;
        first_reg      <= first_next;
        cnt_reg        <= cnt_next;
        emit_i_reg     <= emit_i_next;
        res_reg        <= res_next;
    end

`ifndef ASSERT_OFF
    a_ready_idle: assert property (@(posedge clk) disable iff (!rst_n)
        in_ch.ready |-> !out_valid_reg)
        else $error("input ready while a result is pending");
    a_clr_block: assert property (@(posedge clk) disable iff (!rst_n)
        clr_busy_reg |-> !in_ch.ready)
        else $error("input accepted during clearing pass");
    a_count_max: assert property (@(posedge clk) disable iff (!rst_n)
        32'(count_reg) <= MaxEntries)
        else $error("entry count overflow");
`endif
endmodule

// ----- test/sparse_pattern_crs_ccs_index_core_tb.sv -----
// ----------------------------------------------------------------------------
// sparse_pattern_crs_ccs_index_core_tb
// Drives coordinate loads, table builds and line queries through the
// valid/ready channels under random idling on both sides. A behavioral copy
// of the occupancy map predicts every result item, which is checked field by
// field in order. Several row/column settings are used, the extremes included.
// ----------------------------------------------------------------------------
module sparse_pattern_crs_ccs_index_core_tb;
    import spci_pkg::*;

    typedef struct {
        op_t        op;
        logic [5:0] row;
        logic [5:0] col;
        logic [6:0] qidx;
    } pattern_cmd_t;

    logic       clk = 1'b0;
    logic       rst_n = 1'b0;
    logic       cfg_we;
    logic       cfg_index;
    logic [6:0] cfg_data;

    spci_in_if  in_ch ();
    spci_out_if out_ch ();

    sparse_pattern_crs_ccs_index_core dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_ch     (in_ch),
        .out_ch    (out_ch),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // pattern model
    bit         occ [64][64];
    int         stored_count;
    bit         tables_ready;
    logic [6:0] rows_reg;
    logic [6:0] cols_reg;

    pattern_cmd_t pending_cmds[$];
    result_t      expected_lines[$];
    pattern_cmd_t cur_cmd;

    int errors;
    int cmds_done;
    int results_seen;
    int builds_done;
    int queries_done;
    int cycle_count;

    function automatic int dim_in_use(input logic [6:0] v);
        if (v == 7'd0)
            return 1;
        if (v > 7'd64)
            return 64;
        return int'(v);
    endfunction

    function automatic result_t single_line(input int maxc, input status_t st,
                                            input bit empty);
        result_t r;
        r.line_index = '0;
        r.last       = 1'b1;
        r.empty_res  = empty;
        r.max_count  = 7'(maxc);
        r.status     = st;
        return r;
    endfunction

    function automatic void expect_line(input result_t r);
        expected_lines.insert(expected_lines.size(), r);
    endfunction

    task automatic predict_lines(input pattern_cmd_t c);
        int      m;
        int      n;
        int      best;
        int      cnt;
        int      hits[$];
        result_t r;
        m = dim_in_use(rows_reg);
        n = dim_in_use(cols_reg);
        case (c.op)
            OP_LOAD:
            begin
                if (int'(c.row) >= m || int'(c.col) >= n)
                    expect_line(single_line(0, ST_RANGE, 0));
                else if (occ[c.row][c.col])
                    expect_line(single_line(0, ST_DUP, 0));
                else if (stored_count >= MaxEntries)
                    expect_line(single_line(0, ST_RANGE, 0));
                else
                begin
                    occ[c.row][c.col] = 1'b1;
                    stored_count++;
                    tables_ready = 1'b0;
                    expect_line(single_line(0, ST_OK, 0));
                end
            end
            OP_BUILD:
            begin
                best = 0;
                for (int r0 = 0; r0 < m; r0++)
                begin
                    cnt = 0;
                    for (int c0 = 0; c0 < n; c0++)
                        cnt += occ[r0][c0];
                    if (cnt > best)
                        best = cnt;
                end
                for (int c0 = 0; c0 < n; c0++)
                begin
                    cnt = 0;
                    for (int r0 = 0; r0 < m; r0++)
                        cnt += occ[r0][c0];
                    if (cnt > best)
                        best = cnt;
                end
                tables_ready = 1'b1;
                builds_done++;
                expect_line(single_line(best, ST_OK, 0));
            end
            OP_QUERY:
            begin
                if (!tables_ready || int'(c.qidx) >= m + n)
                    expect_line(single_line(0, ST_BADQ, 0));
                else
                begin
                    queries_done++;
                    if (int'(c.qidx) < m)
                    begin
                        for (int c0 = 0; c0 < n; c0++)
                            if (occ[c.qidx][c0])
                                hits.insert(hits.size(), c0 + m);
                    end
                    else
                    begin
                        for (int r0 = 0; r0 < m; r0++)
                            if (occ[r0][int'(c.qidx) - m])
                                hits.insert(hits.size(), r0);
                    end
                    if (hits.size() == 0)
                        expect_line(single_line(0, ST_OK, 1));
                    foreach (hits[i])
                    begin
                        r = single_line(0, ST_OK, 0);
                        r.line_index = 7'(hits[i]);
                        r.last = (i == hits.size() - 1);
                        expect_line(r);
                    end
                end
            end
            default:
                expect_line(single_line(0, ST_BADQ, 0));
        endcase
    endtask

    // long calm stretch at the start of each cycle_count period, random breaks after
    function automatic bit take_break();
        if ((cycle_count % 2000) < 400)
            return 1'b0;
        return $urandom_range(99) < 35;
    endfunction

    always @(posedge clk)
        cycle_count <= cycle_count + 1;

    // driver
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (in_ch.valid && in_ch.ready)
            begin
                predict_lines(cur_cmd);
                cmds_done++;
            end
            if (!in_ch.valid || in_ch.ready)
            begin
                if (pending_cmds.size() > 0 && !take_break())
                begin
                    cur_cmd = pending_cmds.pop_front();
                    in_ch.valid       <= 1'b1;
                    in_ch.operation   <= cur_cmd.op;
                    in_ch.entry_row   <= cur_cmd.row;
                    in_ch.entry_col   <= cur_cmd.col;
                    in_ch.query_index <= cur_cmd.qidx;
                end
                else
                    in_ch.valid <= 1'b0;
            end
        end
    end

    // monitor
    always @(posedge clk)
    begin
        result_t exp_r;
        if (rst_n)
        begin
            if (out_ch.valid && out_ch.ready)
            begin
                results_seen++;
                if (expected_lines.size() == 0)
                begin
                    errors++;
                    $display("%0t: unexpected result transaction line=%0d status=%0d",
                             $time, out_ch.line_index, out_ch.status);
                end
                else
                begin
                    exp_r = expected_lines.pop_front();
                    if (out_ch.line_index !== exp_r.line_index)
                    begin
                        errors++;
                        $display("%0t: line_index expected %0d actual %0d",
                                 $time, exp_r.line_index, out_ch.line_index);
                    end
                    if (out_ch.last !== exp_r.last)
                    begin
                        errors++;
                        $display("%0t: last expected %0d actual %0d",
                                 $time, exp_r.last, out_ch.last);
                    end
                    if (out_ch.empty_res !== exp_r.empty_res)
                    begin
                        errors++;
                        $display("%0t: empty_res expected %0d actual %0d",
                                 $time, exp_r.empty_res, out_ch.empty_res);
                    end
                    if (out_ch.max_count !== exp_r.max_count)
                    begin
                        errors++;
                        $display("%0t: max_count expected %0d actual %0d",
                                 $time, exp_r.max_count, out_ch.max_count);
                    end
                    if (out_ch.status !== exp_r.status)
                    begin
                        errors++;
                        $display("%0t: status expected %0d actual %0d",
                                 $time, exp_r.status, out_ch.status);
                    end
                end
            end
            out_ch.ready <= !take_break();
        end
    end

    task automatic add_cmd(input op_t op, input int row, input int col, input int q);
        pattern_cmd_t c;
        c.op   = op;
        c.row  = 6'(row);
        c.col  = 6'(col);
        c.qidx = 7'(q);
        pending_cmds.insert(pending_cmds.size(), c);
    endtask

    task automatic write_dims(input logic [6:0] rows, input logic [6:0] cols);
        @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= CfgRows;
        cfg_data  <= rows;
        @(posedge clk);
        cfg_index <= CfgCols;
        cfg_data  <= cols;
        @(posedge clk);
        cfg_we <= 1'b0;
        rows_reg     = rows;
        cols_reg     = cols;
        tables_ready = 1'b0;
    endtask

    task automatic drain();
        @(negedge clk);
        while (pending_cmds.size() > 0 || in_ch.valid || expected_lines.size() > 0)
            @(negedge clk);
        repeat (10) @(posedge clk);
    endtask

    // well-formed load/build/query runs with some noise mixed in
    task automatic random_phase(input int budget);
        int m;
        int n;
        int used;
        int k;
        m = dim_in_use(rows_reg);
        n = dim_in_use(cols_reg);
        used = 0;
        while (used < budget)
        begin
            k = $urandom_range(10, 2);
            for (int i = 0; i < k; i++)
            begin
                if ($urandom_range(9) == 0)
                    add_cmd(OP_LOAD, $urandom_range(63), $urandom_range(63), 0);
                else
                    add_cmd(OP_LOAD, $urandom_range(m - 1), $urandom_range(n - 1), 0);
            end
            used += k;
            if ($urandom_range(5) == 0)
            begin
                add_cmd($urandom_range(1) ? OP_BAD : OP_QUERY, $urandom_range(63),
                        $urandom_range(63), $urandom_range(127));
                used++;
            end
            add_cmd(OP_BUILD, $urandom_range(63), $urandom_range(63), $urandom_range(127));
            k = $urandom_range(7, 3);
            for (int i = 0; i < k; i++)
            begin
                if ($urandom_range(7) == 0)
                    add_cmd(OP_QUERY, 0, 0, $urandom_range(127));
                else
                    add_cmd(OP_QUERY, $urandom_range(63), $urandom_range(63),
                            $urandom_range(m + n - 1));
            end
            used += k + 1;
        end
        drain();
    endtask

    initial
    begin
        logic [6:0] dims [8][2];
        in_ch.valid       = 1'b0;
        in_ch.operation   = OP_LOAD;
        in_ch.entry_row   = '0;
        in_ch.entry_col   = '0;
        in_ch.query_index = '0;
        out_ch.ready      = 1'b0;
        cfg_we            = 1'b0;
        cfg_index         = CfgRows;
        cfg_data          = '0;
        rows_reg          = 7'd64;
        cols_reg          = 7'd64;
        tables_ready      = 1'b0;
        stored_count      = 0;
        errors            = 0;
        cycle_count       = 0;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;

        // directed part at the reset dimensions
        add_cmd(OP_QUERY, 0, 0, 0);
        add_cmd(OP_LOAD, 0, 0, 0);
        add_cmd(OP_LOAD, 63, 63, 0);
        add_cmd(OP_LOAD, 0, 63, 0);
        add_cmd(OP_LOAD, 63, 0, 0);
        add_cmd(OP_LOAD, 0, 0, 0);
        add_cmd(OP_LOAD, 42, 21, 0);
        add_cmd(OP_BAD, 63, 63, 127);
        add_cmd(OP_BUILD, 0, 0, 0);
        add_cmd(OP_QUERY, 0, 0, 0);
        add_cmd(OP_QUERY, 0, 0, 63);
        add_cmd(OP_QUERY, 0, 0, 64);
        add_cmd(OP_QUERY, 0, 0, 127);
        add_cmd(OP_QUERY, 0, 0, 85);
        add_cmd(OP_QUERY, 0, 0, 5);
        add_cmd(OP_LOAD, 5, 5, 0);
        add_cmd(OP_QUERY, 0, 0, 5);
        add_cmd(OP_BUILD, 0, 0, 0);
        add_cmd(OP_QUERY, 0, 0, 5);
        add_cmd(OP_QUERY, 0, 0, 69);
        drain();

        dims = '{'{7'd64, 7'd64}, '{7'd1, 7'd1}, '{7'd0, 7'd0}, '{7'd127, 7'd127},
                 '{7'd5, 7'd9}, '{7'd12, 7'd3}, '{7'd33, 7'd64}, '{7'd64, 7'd17}};
        foreach (dims[p])
        begin
            write_dims(dims[p][0], dims[p][1]);
            // stale table check right after a register write
            add_cmd(OP_QUERY, 0, 0, 0);
            random_phase((dims[p][0] == 7'd64 && dims[p][1] == 7'd64) ? 20 : 26);
        end

        drain();
        repeat (50) @(posedge clk);
        $display("covered %0d input transactions, %0d result transactions",
                 cmds_done, results_seen);
        $display("%0d table builds, %0d served queries over 8 row/column settings",
                 builds_done, queries_done);
        if (errors == 0)
            $display("sparse_pattern_crs_ccs_index_core: match");
        else
            $display("sparse_pattern_crs_ccs_index_core: mismatch");
        $finish;
    end

    initial
    begin
        #30000000;
        $display("timeout with %0d results still expected", expected_lines.size());
        $display("sparse_pattern_crs_ccs_index_core: mismatch");
        $finish;
    end

endmodule

// ----- sparse_pattern_crs_ccs_index_core.f -----
sv/spci_pkg.sv
sv/spci_if.sv
sv/spci_ram.sv
sv/sparse_pattern_crs_ccs_index_core.sv
test/sparse_pattern_crs_ccs_index_core_tb.sv
